// File: hdl/hebm_pkg.sv
// Shared types and constants of the harvest energy budget manager.
`default_nettype none
package hebm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BATT_CAP  = 3'd0;
  localparam logic [2:0] REG_BUD_CEIL  = 3'd1;
  localparam logic [2:0] REG_BUD_FLOOR = 3'd2;
  localparam logic [2:0] REG_LEAK      = 3'd3;
  localparam logic [2:0] REG_RES_OFS   = 3'd4;
  localparam logic [2:0] REG_CHG_EFF   = 3'd5;
  localparam logic [2:0] REG_DEBOUNCE  = 3'd6;
  localparam logic [2:0] REG_DAY_END   = 3'd7;

  localparam int unsigned CFG_W = 31;

  // Operation codes
  localparam logic OP_NEW_SLOT = 1'b0;
  localparam logic OP_UNUSED   = 1'b1;

  // Register reset values
  localparam logic [30:0] BATT_CAP_RST  = 31'd100000000;
  localparam logic [14:0] BUD_CEIL_RST  = 15'd125;
  localparam logic [14:0] BUD_FLOOR_RST = 15'd50;
  localparam logic [15:0] LEAK_RST      = 16'd0;
  localparam logic [30:0] RES_OFS_RST   = 31'd1000000;
  localparam logic [15:0] CHG_EFF_RST   = 16'd48497;
  localparam logic [4:0]  DEBOUNCE_RST  = 5'd20;
  localparam logic [15:0] DAY_END_RST   = 16'd287;

  localparam logic [15:0] SLOT_NONE  = 16'hffff;
  localparam logic [17:0] DISCH_MULT = 18'd300;

  // Divider step counts
  localparam logic [5:0] DIVP_STEPS = 6'd24;
  localparam logic [5:0] DIVE_STEPS = 6'd48;

  typedef struct packed {
    logic        op;
    logic [15:0] amount;
  } in_t;

  typedef struct packed {
    logic [15:0] energy_budget;
    logic [30:0] battery_level;
    logic        is_ready;
    logic        is_day;
  } out_t;

  typedef enum logic [18:0] {
    ST_IDLE  = 19'b000_0000_0000_0000_0001,
    ST_TRACK = 19'b000_0000_0000_0000_0010,
    ST_NMUL  = 19'b000_0000_0000_0000_0100,
    ST_NRES  = 19'b000_0000_0000_0000_1000,
    ST_PSET  = 19'b000_0000_0000_0001_0000,
    ST_DIVP  = 19'b000_0000_0000_0010_0000,
    ST_PEND  = 19'b000_0000_0000_0100_0000,
    ST_PMUL  = 19'b000_0000_0000_1000_0000,
    ST_PHI   = 19'b000_0000_0001_0000_0000,
    ST_E1    = 19'b000_0000_0010_0000_0000,
    ST_DIVE  = 19'b000_0000_0100_0000_0000,
    ST_E2    = 19'b000_0000_1000_0000_0000,
    ST_U1    = 19'b000_0001_0000_0000_0000,
    ST_U2    = 19'b000_0010_0000_0000_0000,
    ST_U3    = 19'b000_0100_0000_0000_0000,
    ST_U4    = 19'b000_1000_0000_0000_0000,
    ST_U5    = 19'b001_0000_0000_0000_0000,
    ST_DONE  = 19'b010_0000_0000_0000_0000,
    ST_SPARE = 19'b100_0000_0000_0000_0000
  } state_e;

endpackage
`default_nettype wire

// File: hdl/harvest_energy_budget_manager_core.sv
// Energy budget manager: sequencer around a shared multiplier and divider.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_stall_o | in_data_i  (hebm_pkg::in_t)
//  out     | out | out_valid_o/out_stall_i | out_data_o (hebm_pkg::out_t)
//  cfg     | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A new slot runs from acceptance to a valid result through up to 24 divider
// steps for the share p, 48 for the recharge term and ten further steps.
// An unused energy report runs the report steps up to U5, then DONE; any transaction
// before the first night goes from its first step straight to DONE. IDLE then takes the next input.
// The result sits in an output register; the next input is taken meanwhile.
// A stalled result holds the sequencer in its last step.
// Reset is asynchronous; state, configuration and control registers go to their defaults.
`default_nettype none
module harvest_energy_budget_manager_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire hebm_pkg::in_t            in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output hebm_pkg::out_t                out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [2:0]               cfg_idx_i,
  input  wire logic [hebm_pkg::CFG_W-1:0] cfg_data_i
);

  hebm_pkg::state_e state_q, state_d;

  // configuration
  logic [30:0] cap_q;
  logic [14:0] ceil_q, floor_q;
  logic [15:0] leak_q, eff_q, dayend_q;
  logic [30:0] ofs_q;
  logic [4:0]  deb_q;

  // block state
  logic [30:0] batt_q;
  logic [14:0] bud_q;
  logic        night_q, ready_q, qd_q, last_q;
  logic [30:0] phi_q;
  logic [15:0] nss_q, nds_q, dl_q, slot_q, ls_q;
  logic [31:0] neut_q;
  logic [4:0]  cc_q;

  // transaction and datapath
  logic [15:0] amt_q;
  logic [16:0] span_q;
  logic [15:0] p_q;
  logic        dneg_q;
  logic signed [17:0] delta_q;
  logic [17:0] mul_a;
  logic [31:0] mul_b;
  logic [49:0] mul_q;
  logic [47:0] quo_q;
  logic [16:0] rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        out_valid_q;
  hebm_pkg::out_t out_q;

  logic in_acc;
  assign in_acc     = in_valid_i && (state_q == hebm_pkg::ST_IDLE);
  assign in_stall_o = (state_q != hebm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic logic [14:0] clamp_e(input logic signed [50:0] v,
                                          input logic [14:0] lo,
                                          input logic [14:0] hi);
    logic signed [50:0] r;
    r = v;
    if (r < $signed({36'd0, lo})) r = $signed({36'd0, lo});
    if (r > $signed({36'd0, hi})) r = $signed({36'd0, hi});
    return r[14:0];
  endfunction

  // ---- slot tracking ----
  logic [15:0] t_slot, t_dl, t_nss, t_nds;
  logic        t_raw, t_q, t_qd, t_night, t_ready, t_last, t_nstart;
  logic [4:0]  t_cc;
  logic signed [17:0] t_span;
  always_comb begin
    t_slot = slot_q + 16'd1;
    t_dl   = ((t_slot > dl_q) && (dl_q != 16'd0)) ? t_slot : dl_q;
    t_raw  = (amt_q > 16'd1);
    t_qd   = qd_q;
    t_cc   = cc_q;
    t_q    = t_raw;
    if (t_raw != qd_q) begin
      t_cc = cc_q + 5'd1;
      if (cc_q < deb_q) begin
        t_q = qd_q;
      end else begin
        t_qd = t_raw;
        t_cc = 5'd0;
      end
    end else begin
      t_cc = 5'd0;
    end
    t_night  = night_q;
    t_ready  = ready_q;
    t_last   = last_q;
    t_nss    = nss_q;
    t_nds    = nds_q;
    t_nstart = 1'b0;
    if (t_q != last_q) begin
      if (t_q) begin
        if (night_q) begin
          if (ready_q) t_nds = t_slot;
          t_slot  = 16'd1;
          t_night = 1'b0;
        end
        t_last = t_q;
      end else if (!night_q && (amt_q == 16'd0)) begin
        t_ready  = 1'b1;
        t_night  = 1'b1;
        t_nss    = t_slot;
        if (nds_q == hebm_pkg::SLOT_NONE) t_nds = dayend_q;
        t_dl     = t_nds - 16'd1;
        t_nstart = 1'b1;
        t_last   = t_q;
      end
    end
    t_span = 18'sd1 + $signed({2'b0, t_dl}) - $signed({2'b0, t_nss});
  end

  // ---- share p setup ----
  logic signed [17:0] p_num, p_den;
  logic [16:0] p_anum, p_aden;
  logic [23:0] p_dvd;
  logic        p_one;
  always_comb begin
    if (qd_q) begin
      p_num = $signed({2'b0, slot_q}) - 18'sd1;
      p_den = $signed({2'b0, nss_q}) - 18'sd1;
    end else begin
      p_num = 18'sd1 + $signed({2'b0, dl_q}) - $signed({2'b0, slot_q});
      p_den = 18'sd1 + $signed({2'b0, dl_q}) - $signed({2'b0, nss_q});
    end
    p_anum = p_num[17] ? 17'(-p_num) : p_num[16:0];
    p_aden = p_den[17] ? 17'(-p_den) : p_den[16:0];
    p_dvd  = ({7'd0, p_anum} << 6) + ({7'd0, p_anum} << 5) + ({7'd0, p_anum} << 2);
    p_one  = (p_den == 18'sd0) || (p_num == 18'sd0) || (p_num[17] ^ p_den[17]);
  end

  // ---- budget terms ----
  logic signed [50:0] e1_v, e2_v;
  logic signed [33:0] d_v;
  logic [14:0] e1_c, e2_c;
  logic [31:0] d_abs;
  logic [47:0] q_mag;
  always_comb begin
    d_v   = $signed({3'd0, batt_q}) - $signed({3'd0, phi_q}) - $signed({3'd0, ofs_q});
    d_abs = d_v[33] ? 32'(-d_v) : d_v[31:0];
    e1_v  = 51'(d_v) + $signed({35'd0, amt_q}) - $signed({35'd0, leak_q});
    e1_c  = clamp_e(e1_v, floor_q, ceil_q);
    q_mag = quo_q;
    e2_v  = $signed({35'd0, amt_q}) - $signed({35'd0, leak_q})
            + (dneg_q ? -$signed({3'd0, q_mag}) : $signed({3'd0, q_mag}));
    e2_c  = clamp_e(e2_v, floor_q, ceil_q);
  end

  // ---- divider step ----
  logic [17:0] dv_sh;
  logic        dv_ge;
  assign dv_sh = {rem_q, quo_q[47]};
  assign dv_ge = (dv_sh >= {1'b0, dvs_q});

  // ---- report terms ----
  logic signed [32:0] lvl_v;
  logic [16:0] dl_abs;
  assign dl_abs = delta_q[17] ? 17'(-delta_q) : delta_q[16:0];
  always_comb begin
    lvl_v = dneg_q ? $signed({2'd0, batt_q}) - $signed({7'd0, mul_q[25:0]})
                   : $signed({2'd0, batt_q}) + $signed({7'd0, mul_q[25:0]});
  end

  // ---- shared multiplier operands ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      hebm_pkg::ST_NMUL: begin
        mul_a = {1'b0, {2'b0, floor_q} + {1'b0, leak_q}};
        mul_b = {15'd0, span_q};
      end
      hebm_pkg::ST_PMUL: begin
        mul_a = {2'b0, p_q} + {1'b0, p_q, 1'b0};
        mul_b = neut_q;
      end
      hebm_pkg::ST_U2: begin
        mul_a = {2'b0, ls_q - {1'b0, bud_q}};
        mul_b = {16'd0, eff_q};
      end
      hebm_pkg::ST_U4: begin
        mul_a = hebm_pkg::DISCH_MULT;
        mul_b = {15'd0, dl_abs};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      hebm_pkg::ST_IDLE:
        if (in_acc) state_d = (in_data_i.op == hebm_pkg::OP_UNUSED) ? hebm_pkg::ST_U1
                                                                   : hebm_pkg::ST_TRACK;
      hebm_pkg::ST_TRACK:
        if (!t_ready)     state_d = hebm_pkg::ST_DONE;
        else if (t_nstart) state_d = hebm_pkg::ST_NMUL;
        else               state_d = hebm_pkg::ST_PSET;
      hebm_pkg::ST_NMUL: state_d = hebm_pkg::ST_NRES;
      hebm_pkg::ST_NRES: state_d = hebm_pkg::ST_PSET;
      hebm_pkg::ST_PSET: state_d = p_one ? hebm_pkg::ST_PMUL : hebm_pkg::ST_DIVP;
      hebm_pkg::ST_DIVP: if (cnt_q == 6'd1) state_d = hebm_pkg::ST_PEND;
      hebm_pkg::ST_PEND: state_d = hebm_pkg::ST_PMUL;
      hebm_pkg::ST_PMUL: state_d = hebm_pkg::ST_PHI;
      hebm_pkg::ST_PHI:  state_d = hebm_pkg::ST_E1;
      hebm_pkg::ST_E1:   state_d = ({1'b0, amt_q} > {2'b0, e1_c}) ? hebm_pkg::ST_DIVE
                                                                  : hebm_pkg::ST_DONE;
      hebm_pkg::ST_DIVE: if (cnt_q == 6'd1) state_d = hebm_pkg::ST_E2;
      hebm_pkg::ST_E2:   state_d = hebm_pkg::ST_DONE;
      hebm_pkg::ST_U1:   state_d = ready_q ? hebm_pkg::ST_U2 : hebm_pkg::ST_DONE;
      hebm_pkg::ST_U2:   state_d = (ls_q > {1'b0, bud_q}) ? hebm_pkg::ST_U3 : hebm_pkg::ST_U4;
      hebm_pkg::ST_U3:   state_d = hebm_pkg::ST_U4;
      hebm_pkg::ST_U4:   state_d = hebm_pkg::ST_U5;
      hebm_pkg::ST_U5:   state_d = hebm_pkg::ST_DONE;
      hebm_pkg::ST_DONE: if (!out_valid_q || !out_stall_i) state_d = hebm_pkg::ST_IDLE;
      default:           state_d = hebm_pkg::ST_IDLE;
    endcase
  end

  // ---- control and state registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hebm_pkg::ST_IDLE;
      cap_q       <= hebm_pkg::BATT_CAP_RST;
      ceil_q      <= hebm_pkg::BUD_CEIL_RST;
      floor_q     <= hebm_pkg::BUD_FLOOR_RST;
      leak_q      <= hebm_pkg::LEAK_RST;
      ofs_q       <= hebm_pkg::RES_OFS_RST;
      eff_q       <= hebm_pkg::CHG_EFF_RST;
      deb_q       <= hebm_pkg::DEBOUNCE_RST;
      dayend_q    <= hebm_pkg::DAY_END_RST;
      batt_q      <= hebm_pkg::BATT_CAP_RST;
      bud_q       <= '0;
      night_q     <= 1'b1;
      ready_q     <= 1'b0;
      phi_q       <= '0;
      nss_q       <= '0;
      nds_q       <= hebm_pkg::SLOT_NONE;
      dl_q        <= '0;
      slot_q      <= 16'd1;
      last_q      <= 1'b0;
      neut_q      <= '0;
      ls_q        <= '0;
      cc_q        <= '0;
      qd_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hebm_pkg::REG_BATT_CAP:  cap_q    <= cfg_data_i[30:0];
          hebm_pkg::REG_BUD_CEIL:  ceil_q   <= cfg_data_i[14:0];
          hebm_pkg::REG_BUD_FLOOR: floor_q  <= cfg_data_i[14:0];
          hebm_pkg::REG_LEAK:      leak_q   <= cfg_data_i[15:0];
          hebm_pkg::REG_RES_OFS:   ofs_q    <= cfg_data_i[30:0];
          hebm_pkg::REG_CHG_EFF:   eff_q    <= cfg_data_i[15:0];
          hebm_pkg::REG_DEBOUNCE:  deb_q    <= cfg_data_i[4:0];
          hebm_pkg::REG_DAY_END:   dayend_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if ((state_q == hebm_pkg::ST_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        hebm_pkg::ST_TRACK: begin
          slot_q  <= t_slot;
          dl_q    <= t_dl;
          cc_q    <= t_cc;
          qd_q    <= t_qd;
          night_q <= t_night;
          ready_q <= t_ready;
          last_q  <= t_last;
          nss_q   <= t_nss;
          nds_q   <= t_nds;
          if (!t_ready) begin
            neut_q <= '0;
            phi_q  <= '0;
          end
        end
        hebm_pkg::ST_NRES:
          neut_q <= (mul_q[49:32] != '0) ? 32'hffff_ffff : mul_q[31:0];
        hebm_pkg::ST_PSET:
          if (!p_one) cnt_q <= hebm_pkg::DIVP_STEPS;
        hebm_pkg::ST_DIVP, hebm_pkg::ST_DIVE:
          cnt_q <= cnt_q - 6'd1;
        hebm_pkg::ST_PHI:
          phi_q <= (mul_q[49:31] != '0) ? 31'h7fff_ffff : mul_q[30:0];
        hebm_pkg::ST_E1: begin
          ls_q <= amt_q;
          if ({1'b0, amt_q} > {2'b0, e1_c}) cnt_q <= hebm_pkg::DIVE_STEPS;
          else bud_q <= e1_c;
        end
        hebm_pkg::ST_E2:
          bud_q <= e2_c;
        hebm_pkg::ST_U1:
          if (ready_q && ({1'b0, bud_q} > amt_q)) bud_q <= 15'({1'b0, bud_q} - amt_q);
        hebm_pkg::ST_U5: begin
          if (lvl_v < 33'sd0) batt_q <= '0;
          else if (lvl_v > $signed({2'd0, cap_q})) batt_q <= cap_q;
          else batt_q <= lvl_v[30:0];
        end
        default: ;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    case (state_q)
      hebm_pkg::ST_IDLE:
        if (in_acc) begin
          amt_q <= in_data_i.amount;
        end
      hebm_pkg::ST_TRACK:
        span_q <= t_span[17] ? 17'd0 : t_span[16:0];
      hebm_pkg::ST_PSET: begin
        p_q   <= 16'd1;
        quo_q <= {p_dvd, 24'd0};
        rem_q <= '0;
        dvs_q <= p_aden;
      end
      hebm_pkg::ST_DIVP, hebm_pkg::ST_DIVE: begin
        quo_q <= {quo_q[46:0], dv_ge};
        rem_q <= dv_ge ? 17'(dv_sh - {1'b0, dvs_q}) : dv_sh[16:0];
      end
      hebm_pkg::ST_PEND:
        if (quo_q[23:0] == 24'd0)   p_q <= 16'd1;
        else if (quo_q[23:16] != 8'd0) p_q <= 16'hffff;
        else                          p_q <= quo_q[15:0];
      hebm_pkg::ST_E1: begin
        dneg_q <= d_v[33];
        quo_q  <= {d_abs, 16'd0};
        rem_q  <= '0;
        dvs_q  <= {1'b0, (eff_q != 16'd0) ? eff_q : 16'd1};
      end
      hebm_pkg::ST_U2:
        if (!(ls_q > {1'b0, bud_q}))
          delta_q <= $signed({2'b0, ls_q}) - $signed({3'b0, bud_q}) - $signed({2'b0, leak_q});
      hebm_pkg::ST_U3:
        delta_q <= $signed({2'b0, mul_q[31:16]}) - $signed({2'b0, leak_q});
      hebm_pkg::ST_U4:
        dneg_q <= delta_q[17];
      hebm_pkg::ST_DONE:
        if (!out_valid_q || !out_stall_i) begin
          out_q.energy_budget <= {1'b0, bud_q};
          out_q.battery_level <= batt_q;
          out_q.is_ready      <= ready_q;
          out_q.is_day        <= qd_q;
        end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
